@@ rtl/core/kbv_pkg.sv @@
// Package for the kinematic body velocity step: constants, sequencer codes
// and small saturation helpers. Depends on nothing.
package kbv_pkg;

   localparam int unsigned DataW    = 32;
   localparam int unsigned CfgW     = 31;
   localparam int unsigned CsrAddrW = 2;
   localparam int unsigned ReqW     = 280;
   localparam int unsigned RspW     = 128;

   localparam logic [CsrAddrW-1:0] CSR_BODY_MASS = 2'd0;
   localparam logic [CsrAddrW-1:0] CSR_FRICTION  = 2'd1;
   localparam logic [CsrAddrW-1:0] CSR_FALL_LIM  = 2'd2;
   localparam logic [CsrAddrW-1:0] CSR_GRAV_EN   = 2'd3;

   localparam logic [CfgW-1:0] MASS_RESET     = 31'd65536;
   localparam logic [CfgW-1:0] FRICTION_RESET = 31'd65536;
   localparam logic [CfgW-1:0] FALL_LIM_RESET = 31'd642253;

   localparam logic [19:0] GRAVITY_RAW   = 20'd969933;
   localparam logic signed [31:0] WALL_PUSH = 32'sd6554;

   localparam logic [1:0] WALL_NONE  = 2'd0;
   localparam logic [1:0] WALL_LEFT  = 2'd1;
   localparam logic [1:0] WALL_RIGHT = 2'd2;
   localparam logic [1:0] WALL_TOP   = 2'd3;

   typedef enum logic [26:0] {
      ST_IDLE  = 27'h0000001,
      ST_GRAVM = 27'h0000002,
      ST_GRAV  = 27'h0000004,
      ST_LDX   = 27'h0000008,
      ST_DIVX  = 27'h0000010,
      ST_ACCX  = 27'h0000020,
      ST_LDY   = 27'h0000040,
      ST_DIVY  = 27'h0000080,
      ST_ACCY  = 27'h0000100,
      ST_MIX   = 27'h0000200,
      ST_CHK   = 27'h0000400,
      ST_SQY   = 27'h0000800,
      ST_SQS   = 27'h0001000,
      ST_SQRT  = 27'h0002000,
      ST_LDR   = 27'h0004000,
      ST_DIVR  = 27'h0008000,
      ST_MU    = 27'h0010000,
      ST_FLO   = 27'h0020000,
      ST_FHI   = 27'h0040000,
      ST_FSC   = 27'h0080000,
      ST_FM1   = 27'h0100000,
      ST_FM2   = 27'h0200000,
      ST_FRIC  = 27'h0400000,
      ST_PX    = 27'h0800000,
      ST_PY    = 27'h1000000,
      ST_PYW   = 27'h2000000,
      ST_OUT   = 27'h4000000
   } state_type;

   // saturate a 33-bit sum to 32 bits
   function automatic logic signed [31:0] sat33(input logic signed [32:0] s);
      if (s[32] != s[31]) begin
         return s[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
      end
      return s[31:0];
   endfunction

   function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
      logic signed [32:0] s;
      s = 33'(a) + 33'(b);
      return sat33(s);
   endfunction

endpackage

@@ rtl/core/kinematic_body_velocity_step.sv @@
// Top level of the kinematic body velocity step: one shared multiplier,
// a radix-2 divider and an integer square root under one sequencer.
// An inactive word goes straight to the response; an active word runs up to three
// 64-step divisions through the shared divider plus 32 root steps, and skips the
// root, the third division and friction when the velocity ends at zero.
// One word at a time: req_tready only in idle, so a new word is taken only
// once the response to the last one has been accepted.
// Reset (synchronous): velocity zero, registers to their defaults.
module kinematic_body_velocity_step (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // active, time_step, on_ground, wall_contact, force_x, force_y,
   // added_vel_x, added_vel_y, override_vel_x, override_vel_y, pos_x_in,
   // pos_y_in, zero pad
   input  logic [kbv_pkg::ReqW-1:0]        req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // pos_x_out, pos_y_out, vel_x_out, vel_y_out
   output logic [kbv_pkg::RspW-1:0]        rsp_tdata,
   input  logic                            csr_we,
   input  logic [kbv_pkg::CsrAddrW-1:0]    csr_addr,
   input  logic [kbv_pkg::CfgW-1:0]        csr_wdata
);
   import kbv_pkg::*;

   state_type state_ff, state_in;

   logic [CfgW-1:0] mass_ff, mu_ff, lim_ff;
   logic            gen_ff;

   logic signed [31:0] vx_ff, vx_in, vy_ff, vy_in;
   logic signed [31:0] px_ff, px_in, py_ff, py_in;
   logic signed [31:0] ax_ff, ay_ff, ox_ff, oy_ff, fy_ff, fx_ff;
   logic signed [31:0] px_src_ff, py_src_ff;
   logic [15:0]        dt_ff;
   logic               gnd_ff;
   logic [1:0]         wall_ff;

   logic signed [33:0] mul_a, mul_b;
   logic signed [67:0] prod_ff;

   logic [63:0] dv_num_ff, dv_num_in;
   logic [32:0] dv_rem_ff, dv_rem_in;
   logic [31:0] dv_den_ff, dv_den_in;
   logic        sgn_ff, sgn_in;
   logic [5:0]  cnt_ff, cnt_in;

   logic [63:0] sq_v_ff, sq_v_in, sq_r_ff, sq_r_in;
   logic [63:0] acc_ff, acc_in;
   logic [32:0] r_ff, r_in;
   logic [51:0] f_ff, f_in;

   logic [CfgW-1:0]  mass_eff;
   logic [31:0]      axv, ayv;
   logic [32:0]      rem_sh;
   logic             div_last, sq_last;
   logic [63:0]      sq_b, sq_t;
   logic signed [31:0] term;
   logic signed [33:0] gy;
   logic [19:0]        grav;
   logic signed [31:0] mvx, mvy;
   logic [63:0]        t64, p_abs;
   logic [52:0]        fmag;
   logic signed [47:0] pshift;

   assign mass_eff = (mass_ff == '0) ? CfgW'(1) : mass_ff;
   assign axv = vx_ff[31] ? 32'(-vx_ff) : 32'(vx_ff);
   assign ayv = vy_ff[31] ? 32'(-vy_ff) : 32'(vy_ff);

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {vy_ff, vx_ff, py_ff, px_ff};

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_GRAVM: begin
            mul_a = {14'b0, GRAVITY_RAW};
            mul_b = {18'b0, dt_ff};
         end
         ST_GRAV: begin
            mul_a = 34'(fx_ff);
            mul_b = {18'b0, dt_ff};
         end
         ST_ACCX: begin
            mul_a = 34'(fy_ff);
            mul_b = {18'b0, dt_ff};
         end
         ST_CHK: begin
            mul_a = {2'b0, axv};
            mul_b = {2'b0, axv};
         end
         ST_SQY: begin
            mul_a = {2'b0, ayv};
            mul_b = {2'b0, ayv};
         end
         ST_MU: begin
            mul_a = {3'b0, mu_ff};
            mul_b = {3'b0, mass_eff};
         end
         ST_FLO: begin
            mul_a = {2'b0, prod_ff[47:16]};
            mul_b = {18'b0, dt_ff};
         end
         ST_FHI: begin
            mul_a = {20'b0, f_ff[45:32]};
            mul_b = {18'b0, dt_ff};
         end
         ST_FM1: begin
            mul_a = {2'b0, f_ff[31:0]};
            mul_b = {1'b0, r_ff};
         end
         ST_FM2: begin
            mul_a = {14'b0, f_ff[51:32]};
            mul_b = {1'b0, r_ff};
         end
         ST_PX: begin
            mul_a = 34'(vx_ff);
            mul_b = {18'b0, dt_ff};
         end
         ST_PY: begin
            mul_a = 34'(vy_ff);
            mul_b = {18'b0, dt_ff};
         end
         default: ;
      endcase
   end

   // divider step, root step and other datapath terms
   always_comb begin
      rem_sh   = {dv_rem_ff[31:0], dv_num_ff[63]};
      div_last = (cnt_ff == 6'd0);
      sq_last  = (cnt_ff[4:0] == 5'd0);
      sq_b     = 64'd1 << {cnt_ff[4:0], 1'b0};
      sq_t     = sq_r_ff + sq_b;
      // force term: signed quotient saturated to 32 bits
      if (!sgn_ff) begin
         term = (dv_num_ff > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : signed'(dv_num_ff[31:0]);
      end else begin
         term = (dv_num_ff > 64'h80000000) ? 32'sh80000000 : signed'(32'(-dv_num_ff[31:0]));
      end
      grav = prod_ff[35:16] + 20'(prod_ff[15]);
      gy   = 34'(vy_ff) - 34'(grav);
      if (gy > signed'({3'b0, lim_ff})) begin
         gy = signed'({3'b0, lim_ff});
      end else if (gy < -signed'({3'b0, lim_ff})) begin
         gy = -signed'({3'b0, lim_ff});
      end
      p_abs = prod_ff[67] ? 64'(-prod_ff) : 64'(prod_ff);
      // override or added velocity, then wall push-off
      if (ox_ff != '0 || oy_ff != '0) begin
         mvx = ox_ff;
         mvy = oy_ff;
      end else begin
         mvx = sat_add(vx_ff, ax_ff);
         mvy = sat_add(vy_ff, ay_ff);
      end
      case (wall_ff)
         WALL_LEFT:  if (mvx <= 0) mvx = WALL_PUSH;
         WALL_RIGHT: if (mvx >= 0) mvx = -WALL_PUSH;
         WALL_TOP:   if (mvy >= 0) mvy = -WALL_PUSH;
         default: ;
      endcase
      t64    = acc_ff + {prod_ff[31:0], 32'b0};
      fmag   = 53'(acc_ff[32:0]) + 53'(prod_ff[52:0]);
      // floor of v*dt / 2^16, sign kept
      pshift = signed'(prod_ff[47:0]) >>> 16;
   end

   always_comb begin
      state_in  = state_ff;
      vx_in     = vx_ff;
      vy_in     = vy_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      dv_num_in = dv_num_ff;
      dv_rem_in = dv_rem_ff;
      dv_den_in = dv_den_ff;
      sgn_in    = sgn_ff;
      cnt_in    = cnt_ff;
      sq_v_in   = sq_v_ff;
      sq_r_in   = sq_r_ff;
      acc_in    = acc_ff;
      r_in      = r_ff;
      f_in      = f_ff;
      case (state_ff)
         ST_IDLE: ;
         ST_GRAVM: state_in = ST_GRAV;
         ST_GRAV: begin
            if (gnd_ff) begin
               vy_in = '0;
            end else if (gen_ff) begin
               vy_in = gy[31:0];
            end
            state_in = ST_LDX;
         end
         ST_LDX, ST_LDY: begin
            dv_num_in = p_abs;
            sgn_in    = prod_ff[67];
            dv_den_in = {1'b0, mass_eff};
            dv_rem_in = '0;
            cnt_in    = 6'd63;
            state_in  = (state_ff == ST_LDX) ? ST_DIVX : ST_DIVY;
         end
         ST_DIVX, ST_DIVY, ST_DIVR: begin
            if (rem_sh >= {1'b0, dv_den_ff}) begin
               dv_rem_in = rem_sh - {1'b0, dv_den_ff};
               dv_num_in = {dv_num_ff[62:0], 1'b1};
            end else begin
               dv_rem_in = rem_sh;
               dv_num_in = {dv_num_ff[62:0], 1'b0};
            end
            cnt_in = cnt_ff - 6'd1;
            if (div_last) begin
               case (state_ff)
                  ST_DIVX: state_in = ST_ACCX;
                  ST_DIVY: state_in = ST_ACCY;
                  default: state_in = ST_MU;
               endcase
            end
         end
         ST_ACCX: begin
            vx_in    = sat_add(vx_ff, term);
            state_in = ST_LDY;
         end
         ST_ACCY: begin
            vy_in    = sat_add(vy_ff, term);
            state_in = ST_MIX;
         end
         ST_MIX: begin
            vx_in    = mvx;
            vy_in    = mvy;
            state_in = ST_CHK;
         end
         ST_CHK: state_in = (vx_ff == '0 && vy_ff == '0) ? ST_PX : ST_SQY;
         ST_SQY: begin
            acc_in   = prod_ff[63:0];
            state_in = ST_SQS;
         end
         ST_SQS: begin
            sq_v_in  = acc_ff + prod_ff[63:0];
            sq_r_in  = '0;
            cnt_in   = 6'd31;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (sq_v_ff >= sq_t) begin
               sq_v_in = sq_v_ff - sq_t;
               sq_r_in = (sq_r_ff >> 1) + sq_b;
            end else begin
               sq_r_in = sq_r_ff >> 1;
            end
            cnt_in = cnt_ff - 6'd1;
            if (sq_last) state_in = ST_LDR;
         end
         ST_LDR: begin
            dv_num_in = {axv, 32'b0};
            dv_den_in = (sq_r_ff == '0) ? 32'd1 : sq_r_ff[31:0];
            dv_rem_in = '0;
            cnt_in    = 6'd63;
            state_in  = ST_DIVR;
         end
         ST_MU: begin
            r_in     = (dv_num_ff > 64'h100000000) ? 33'h100000000 : dv_num_ff[32:0];
            state_in = ST_FLO;
         end
         ST_FLO: begin
            f_in     = 52'(prod_ff[61:16]);
            state_in = ST_FHI;
         end
         ST_FHI: begin
            acc_in   = prod_ff[63:0];
            state_in = ST_FSC;
         end
         ST_FSC: begin
            // ground friction is thirty times: 32f - 2f
            f_in     = gnd_ff ? (52'(t64[63:16]) << 5) - (52'(t64[63:16]) << 1)
                              : 52'(t64[63:16]);
            state_in = ST_FM1;
         end
         ST_FM1: state_in = ST_FM2;
         ST_FM2: begin
            acc_in   = 64'(prod_ff[64:32]);
            state_in = ST_FRIC;
         end
         ST_FRIC: begin
            if (53'(axv) < fmag) begin
               vx_in = '0;
            end else if (vx_ff > 0) begin
               vx_in = vx_ff - signed'(fmag[31:0]);
            end else begin
               vx_in = vx_ff + signed'(fmag[31:0]);
            end
            state_in = ST_PX;
         end
         ST_PX: state_in = ST_PY;
         ST_PY: begin
            px_in    = sat33(33'(px_src_ff) + 33'(pshift[32:0]));
            state_in = ST_PYW;
         end
         ST_PYW: begin
            py_in    = sat33(33'(py_src_ff) + 33'(pshift[32:0]));
            state_in = ST_OUT;
         end
         ST_OUT: if (rsp_tready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff   <= mul_a * mul_b;
      dv_num_ff <= dv_num_in;
      dv_rem_ff <= dv_rem_in;
      dv_den_ff <= dv_den_in;
      sgn_ff    <= sgn_in;
      cnt_ff    <= cnt_in;
      sq_v_ff   <= sq_v_in;
      sq_r_ff   <= sq_r_in;
      acc_ff    <= acc_in;
      r_ff      <= r_in;
      f_ff      <= f_in;
      px_ff     <= px_in;
      py_ff     <= py_in;
      if (req_tvalid && req_tready) begin
         dt_ff     <= req_tdata[16:1];
         gnd_ff    <= req_tdata[17];
         wall_ff   <= req_tdata[19:18];
         fx_ff     <= req_tdata[51:20];
         fy_ff     <= req_tdata[83:52];
         ax_ff     <= req_tdata[115:84];
         ay_ff     <= req_tdata[147:116];
         ox_ff     <= req_tdata[179:148];
         oy_ff     <= req_tdata[211:180];
         px_src_ff <= req_tdata[243:212];
         py_src_ff <= req_tdata[275:244];
         px_ff     <= req_tdata[243:212];
         py_ff     <= req_tdata[275:244];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         vx_ff    <= '0;
         vy_ff    <= '0;
         mass_ff  <= MASS_RESET;
         mu_ff    <= FRICTION_RESET;
         lim_ff   <= FALL_LIM_RESET;
         gen_ff   <= 1'b1;
      end else begin
         vx_ff <= vx_in;
         vy_ff <= vy_in;
         // the active bit picks the path at accept
         if (state_ff == ST_IDLE) begin
            if (req_tvalid) state_ff <= req_tdata[0] ? ST_GRAVM : ST_OUT;
         end else begin
            state_ff <= state_in;
         end
         if (csr_we) begin
            case (csr_addr)
               CSR_BODY_MASS: mass_ff <= csr_wdata;
               CSR_FRICTION:  mu_ff   <= csr_wdata;
               CSR_FALL_LIM:  lim_ff  <= csr_wdata;
               CSR_GRAV_EN:   gen_ff  <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

endmodule
